[src/priority_voice_allocator_unit_macros.svh]
// Assertion helpers used by the checker file.
`ifndef PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high.
`define PVA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Overlapped implication built on the macro above.
`define PVA_ASSERT_IMPLY(label, cond, cons, msg) \
   `PVA_ASSERT(label, (cond) |-> (cons), msg)

`endif

[src/pva_pkg.sv]
package pva_pkg;

   localparam int MAX_VOICES  = 64;
   localparam int ACTIVE_MAX  = (MAX_VOICES < 64) ? MAX_VOICES : 64;
   localparam int MIN_VOICES  = 4;

   localparam int VOICE_W     = 6;
   localparam int CNT_W       = 7;
   localparam int ORIGIN_W    = 16;
   localparam int SOUND_W     = 10;
   localparam int PRI_W       = 8;
   localparam int WORD_W      = ORIGIN_W + SOUND_W + PRI_W;

   localparam logic [CNT_W-1:0] VOICES_RESET = CNT_W'(8);

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_STOP    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

endpackage

[src/pva_ram.sv]
module pva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/priority_voice_allocator_unit.sv]
// Voice allocator with priority stealing.
// Request side: drive req_* and pulse start while busy is low; the beat is
// taken on that edge. Opcodes: start sound, stop by origin, release voice.
// Result side: one result beat per request, rsp_valid high for one cycle
// with rsp_* alongside. The receiver cannot stall; it must take every beat.
// Config: csr_voices_in_use is written when csr_valid is high (csr_ready is
// always high); write it only while busy is low and no result is pending.
// Paths, with N the active voice count (4..64), from accept to result:
//   unused opcode, release of a free or out-of-range voice : answered from idle
//   release of a busy voice                               : one release state
//   stop by origin                                        : origin scan of up to N voices
//   start                : origin scan of up to N voices, then a
//                          priority scan when every voice is busy
// busy drops in the result cycle, so the next request is taken on the edge
// that ends it; no new request is taken while one is in progress.
// Each scan, with its own comparator, walks the voice memory one entry per
// cycle through its single registered read port; busy stays high meanwhile.
// Reset clears every busy mark and sets the voice count to 8; the voice
// memory itself is not cleared, entries are only read once marked busy.
module priority_voice_allocator_unit
   import pva_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [ORIGIN_W-1:0] req_origin_id,
   input  logic [SOUND_W-1:0]  req_sound_id,
   input  logic [PRI_W-1:0]    req_priority_req,
   input  logic [VOICE_W-1:0]  req_voice_index,
   output logic                rsp_valid,
   output logic                rsp_granted,
   output logic [VOICE_W-1:0]  rsp_granted_voice,
   output logic                rsp_stopped,
   output logic [VOICE_W-1:0]  rsp_stopped_voice,
   output logic [SOUND_W-1:0]  rsp_stopped_sound,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_W-1:0]    csr_voices_in_use
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_ORG,
      ST_SCAN_PRI,
      ST_RELEASE
   } state_type;

   state_type              state_ff, state_in;
   opcode_type             op_ff, op_in;
   logic [ORIGIN_W-1:0]    org_ff, org_in;
   logic [SOUND_W-1:0]     snd_ff, snd_in;
   logic [PRI_W-1:0]       pri_ff, pri_in;
   logic [VOICE_W-1:0]     idx_ff, idx_in;
   logic [VOICE_W-1:0]     cnt_ff, cnt_in;
   logic                   have_free_ff, have_free_in;
   logic [VOICE_W-1:0]     free_ff, free_in;
   logic [MAX_VOICES-1:0]  busy_ff, busy_in;
   logic [CNT_W-1:0]       voices_ff, voices_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [VOICE_W-1:0]     rsp_granted_voice_ff, rsp_granted_voice_in;
   logic                   rsp_stopped_ff, rsp_stopped_in;
   logic [VOICE_W-1:0]     rsp_stopped_voice_ff, rsp_stopped_voice_in;
   logic [SOUND_W-1:0]     rsp_stopped_sound_ff, rsp_stopped_sound_in;

   logic [VOICE_W-1:0]     last_idx;
   logic [VOICE_W-1:0]     rd_addr;
   logic [WORD_W-1:0]      rd_data;
   logic                   wr_en;
   logic [VOICE_W-1:0]     wr_addr;
   logic                   clr_en, set_en;
   logic [VOICE_W-1:0]     clr_idx, set_idx;
   logic [ORIGIN_W-1:0]    rd_origin;
   logic [SOUND_W-1:0]     rd_sound;
   logic [PRI_W-1:0]       rd_pri;
   logic                   busy_c, is_last, hit_org, hit_pri;
   logic [VOICE_W-1:0]     grant_idx;

   pva_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_VOICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({org_ff, snd_ff, pri_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_origin = rd_data[WORD_W-1 -: ORIGIN_W];
   assign rd_sound  = rd_data[PRI_W +: SOUND_W];
   assign rd_pri    = rd_data[PRI_W-1:0];

   // active count saturated to 4..64
   always_comb begin
      if (voices_ff < CNT_W'(MIN_VOICES)) begin
         last_idx = VOICE_W'(MIN_VOICES - 1);
      end else if (voices_ff > CNT_W'(ACTIVE_MAX)) begin
         last_idx = VOICE_W'(ACTIVE_MAX - 1);
      end else begin
         last_idx = VOICE_W'(voices_ff - CNT_W'(1));
      end
   end

   // separate comparators: origin equality in the first pass, priority in the second
   assign busy_c    = busy_ff[cnt_ff];
   assign is_last   = (cnt_ff == last_idx);
   assign hit_org   = busy_c && (rd_origin == org_ff);
   assign hit_pri   = (rd_pri >= pri_ff);
   assign grant_idx = have_free_ff ? free_ff : cnt_ff;

   always_comb begin
      state_in             = state_ff;
      op_in                = op_ff;
      org_in               = org_ff;
      snd_in               = snd_ff;
      pri_in               = pri_ff;
      idx_in               = idx_ff;
      cnt_in               = cnt_ff;
      have_free_in         = have_free_ff;
      free_in              = free_ff;
      voices_in            = voices_ff;
      rd_addr              = cnt_ff + VOICE_W'(1);
      wr_en                = 1'b0;
      wr_addr              = cnt_ff;
      clr_en               = 1'b0;
      clr_idx              = cnt_ff;
      set_en               = 1'b0;
      set_idx              = cnt_ff;
      rsp_valid_in         = 1'b0;
      rsp_granted_in       = 1'b0;
      rsp_granted_voice_in = '0;
      rsp_stopped_in       = 1'b0;
      rsp_stopped_voice_in = '0;
      rsp_stopped_sound_in = '0;

      if (csr_valid) begin
         voices_in = csr_voices_in_use;
      end

      case (state_ff)
         ST_IDLE: begin
            rd_addr = (opcode_type'(req_opcode) == OP_RELEASE) ? req_voice_index : '0;
            if (start) begin
               op_in        = opcode_type'(req_opcode);
               org_in       = req_origin_id;
               snd_in       = req_sound_id;
               pri_in       = req_priority_req;
               idx_in       = req_voice_index;
               cnt_in       = '0;
               have_free_in = 1'b0;
               case (opcode_type'(req_opcode))
                  OP_START, OP_STOP: begin
                     state_in = ST_SCAN_ORG;
                  end
                  OP_RELEASE: begin
                     if (req_voice_index <= last_idx && busy_ff[req_voice_index]) begin
                        state_in = ST_RELEASE;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN_ORG: begin
            rd_addr = is_last ? '0 : cnt_ff + VOICE_W'(1);
            if (hit_org) begin
               clr_en               = 1'b1;
               rsp_stopped_in       = 1'b1;
               rsp_stopped_voice_in = cnt_ff;
               rsp_stopped_sound_in = rd_sound;
               if (op_ff == OP_START) begin
                  // a free voice seen earlier wins over the freed one
                  wr_en                = 1'b1;
                  wr_addr              = grant_idx;
                  set_en               = 1'b1;
                  set_idx              = grant_idx;
                  rsp_granted_in       = 1'b1;
                  rsp_granted_voice_in = grant_idx;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (is_last) begin
               if (op_ff != OP_START) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else if (have_free_ff || !busy_c) begin
                  wr_en                = 1'b1;
                  wr_addr              = grant_idx;
                  set_en               = 1'b1;
                  set_idx              = grant_idx;
                  rsp_granted_in       = 1'b1;
                  rsp_granted_voice_in = grant_idx;
                  rsp_valid_in         = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_SCAN_PRI;
               end
            end else begin
               cnt_in = cnt_ff + VOICE_W'(1);
               if (!busy_c && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = cnt_ff;
               end
            end
         end

         ST_SCAN_PRI: begin
            // every voice is busy here: steal the first one at or above the value
            if (hit_pri) begin
               wr_en                = 1'b1;
               rsp_stopped_in       = 1'b1;
               rsp_stopped_voice_in = cnt_ff;
               rsp_stopped_sound_in = rd_sound;
               rsp_granted_in       = 1'b1;
               rsp_granted_voice_in = cnt_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end else if (is_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + VOICE_W'(1);
            end
         end

         ST_RELEASE: begin
            clr_en               = 1'b1;
            clr_idx              = idx_ff;
            rsp_stopped_in       = 1'b1;
            rsp_stopped_voice_in = idx_ff;
            rsp_stopped_sound_in = rd_sound;
            rsp_valid_in         = 1'b1;
            state_in             = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      busy_in = busy_ff;
      if (clr_en) begin
         busy_in[clr_idx] = 1'b0;
      end
      if (set_en) begin
         busy_in[set_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         voices_ff    <= VOICES_RESET;
         rsp_valid_ff <= 1'b0;
         have_free_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         voices_ff    <= voices_in;
         rsp_valid_ff <= rsp_valid_in;
         have_free_ff <= have_free_in;
      end
      op_ff                <= op_in;
      org_ff               <= org_in;
      snd_ff               <= snd_in;
      pri_ff               <= pri_in;
      idx_ff               <= idx_in;
      cnt_ff               <= cnt_in;
      free_ff              <= free_in;
      rsp_granted_ff       <= rsp_granted_in;
      rsp_granted_voice_ff <= rsp_granted_voice_in;
      rsp_stopped_ff       <= rsp_stopped_in;
      rsp_stopped_voice_ff <= rsp_stopped_voice_in;
      rsp_stopped_sound_ff <= rsp_stopped_sound_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_granted_voice = rsp_granted_voice_ff;
   assign rsp_stopped       = rsp_stopped_ff;
   assign rsp_stopped_voice = rsp_stopped_voice_ff;
   assign rsp_stopped_sound = rsp_stopped_sound_ff;

endmodule

[src/pva_checker.sv]
`include "priority_voice_allocator_unit_macros.svh"

module pva_checker
   import pva_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic                rsp_granted,
   input logic [VOICE_W-1:0]  rsp_granted_voice,
   input logic                rsp_stopped,
   input logic [VOICE_W-1:0]  rsp_stopped_voice,
   input logic [SOUND_W-1:0]  rsp_stopped_sound
);

   logic grant_clear;
   logic stop_clear;

   assign grant_clear = (rsp_granted_voice == '0);
   assign stop_clear  = (rsp_stopped_voice == '0) && (rsp_stopped_sound == '0);

   // the result beat leaves together with the return to idle
   `PVA_ASSERT_IMPLY(a_rsp_idle, rsp_valid, !busy, "result beat while busy")

   // an accepted request either starts work or answers at once
   `PVA_ASSERT(a_accept_progress, (start && !busy) |=> (busy || rsp_valid), "request dropped")

   `PVA_ASSERT_IMPLY(a_no_grant_zero, rsp_valid && !rsp_granted, grant_clear, "grant not zero")

   `PVA_ASSERT_IMPLY(a_no_stop_zero, rsp_valid && !rsp_stopped, stop_clear, "stop not zero")

endmodule

bind priority_voice_allocator_unit pva_checker u_pva_checker (.*);

[tb/priority_voice_allocator_unit_test.sv]
module priority_voice_allocator_unit_test;
   import pva_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PRINT_CAP   = 100;

   typedef struct packed {
      opcode_type          op;
      logic [ORIGIN_W-1:0] origin;
      logic [SOUND_W-1:0]  sound;
      logic [PRI_W-1:0]    pri;
      logic [VOICE_W-1:0]  index;
   } voice_cmd_type;

   typedef struct packed {
      logic               granted;
      logic [VOICE_W-1:0] granted_voice;
      logic               stopped;
      logic [VOICE_W-1:0] stopped_voice;
      logic [SOUND_W-1:0] stopped_sound;
   } voice_outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_opcode = '0;
   logic [ORIGIN_W-1:0] req_origin_id = '0;
   logic [SOUND_W-1:0]  req_sound_id = '0;
   logic [PRI_W-1:0]    req_priority_req = '0;
   logic [VOICE_W-1:0]  req_voice_index = '0;
   logic                rsp_valid;
   logic                rsp_granted;
   logic [VOICE_W-1:0]  rsp_granted_voice;
   logic                rsp_stopped;
   logic [VOICE_W-1:0]  rsp_stopped_voice;
   logic [SOUND_W-1:0]  rsp_stopped_sound;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_voices_in_use = '0;

   // mirror of the voice table and the count register
   bit                  slot_busy [MAX_VOICES];
   logic [ORIGIN_W-1:0] slot_origin [MAX_VOICES];
   logic [SOUND_W-1:0]  slot_sound [MAX_VOICES];
   logic [PRI_W-1:0]    slot_pri [MAX_VOICES];
   logic [CNT_W-1:0]    voice_count = VOICES_RESET;

   voice_cmd_type     pending_cmds[$];
   voice_outcome_type expected_outcomes[$];
   voice_cmd_type     cur_cmd;
   int                idle_pct = 0;
   int                cmds_queued = 0;
   int                outcomes_seen = 0;
   int                mismatches = 0;
   int                cycles = 0;

   priority_voice_allocator_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_origin_id     (req_origin_id),
      .req_sound_id      (req_sound_id),
      .req_priority_req  (req_priority_req),
      .req_voice_index   (req_voice_index),
      .rsp_valid         (rsp_valid),
      .rsp_granted       (rsp_granted),
      .rsp_granted_voice (rsp_granted_voice),
      .rsp_stopped       (rsp_stopped),
      .rsp_stopped_voice (rsp_stopped_voice),
      .rsp_stopped_sound (rsp_stopped_sound),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_voices_in_use (csr_voices_in_use)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_voices();
      int n;
      n = voice_count;
      if (n < MIN_VOICES) n = MIN_VOICES;
      if (n > ACTIVE_MAX) n = ACTIVE_MAX;
      return n;
   endfunction

   function automatic void free_slot(int v, inout voice_outcome_type r);
      r.stopped       = 1'b1;
      r.stopped_voice = VOICE_W'(v);
      r.stopped_sound = slot_sound[v];
      slot_busy[v]    = 1'b0;
   endfunction

   function automatic void evict_origin(int n, logic [ORIGIN_W-1:0] org,
                                        inout voice_outcome_type r);
      for (int v = 0; v < n; v++) begin
         if (slot_busy[v] && slot_origin[v] == org) begin
            free_slot(v, r);
            break;
         end
      end
   endfunction

   // updates the voice table mirror and returns the outcome of one command
   function automatic voice_outcome_type allocate(voice_cmd_type c);
      voice_outcome_type r;
      int n;
      int slot;
      r = '0;
      n = active_voices();
      slot = n;
      case (c.op)
         OP_START: begin
            evict_origin(n, c.origin, r);
            for (int v = 0; v < n; v++) begin
               if (!slot_busy[v]) begin
                  slot = v;
                  break;
               end
               if (c.origin != '0 && slot_origin[v] == c.origin) begin
                  free_slot(v, r);
                  slot = v;
                  break;
               end
            end
            // table full: steal the first voice that is no more important
            if (slot == n) begin
               for (int v = 0; v < n; v++) begin
                  if (slot_pri[v] >= c.pri) begin
                     slot = v;
                     break;
                  end
               end
               if (slot != n) free_slot(slot, r);
            end
            if (slot != n) begin
               slot_busy[slot]   = 1'b1;
               slot_origin[slot] = c.origin;
               slot_sound[slot]  = c.sound;
               slot_pri[slot]    = c.pri;
               r.granted         = 1'b1;
               r.granted_voice   = VOICE_W'(slot);
            end
         end
         OP_STOP: evict_origin(n, c.origin, r);
         OP_RELEASE: begin
            if (int'(c.index) < n && slot_busy[c.index]) free_slot(int'(c.index), r);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic voice_cmd_type make_cmd(opcode_type op, int org, int snd, int pri,
                                              int idx);
      voice_cmd_type c;
      c.op     = op;
      c.origin = ORIGIN_W'(org);
      c.sound  = SOUND_W'(snd);
      c.pri    = PRI_W'(pri);
      c.index  = VOICE_W'(idx);
      return c;
   endfunction

   // origins drawn mostly from a pool sized to the table so matches happen
   function automatic voice_cmd_type random_cmd(int start_pct);
      voice_cmd_type c;
      int n;
      int r;
      int k;
      n = active_voices();
      r = $urandom_range(0, 99);
      if (r < start_pct) c.op = OP_START;
      else if (r >= 96) c.op = OP_NONE;
      else if (r % 2 == 0) c.op = OP_STOP;
      else c.op = OP_RELEASE;
      k = $urandom_range(0, 99);
      if (k < 12) c.origin = ORIGIN_W'($urandom_range(0, 65535));
      else if (k < 17) c.origin = '1;
      else c.origin = ORIGIN_W'($urandom_range(0, n + n / 2));
      c.sound = SOUND_W'($urandom_range(0, 1023));
      c.pri   = PRI_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) c.index = VOICE_W'($urandom_range(0, 63));
      else c.index = VOICE_W'($urandom_range(0, (n + 1 > 63) ? 63 : n + 1));
      return c;
   endfunction

   task automatic queue_cmd(voice_cmd_type c);
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   // every command yields one result, so the block is idle once all are in
   task automatic wait_drained();
      do @(posedge clock); while (outcomes_seen < cmds_queued);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_voice_count(logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_voices_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      voice_count = value;
      csr_valid   <= 1'b0;
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // driver: holds start until the beat is taken, gaps only between beats
   always @(posedge clock) begin : drive_requests
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_outcomes.push_back(allocate(cur_cmd));
            next_start = 1'b0;
         end
         if (!next_start && pending_cmds.size() != 0 &&
             $urandom_range(0, 99) >= idle_pct) begin
            cur_cmd          = pending_cmds.pop_front();
            req_opcode       <= cur_cmd.op;
            req_origin_id    <= cur_cmd.origin;
            req_sound_id     <= cur_cmd.sound;
            req_priority_req <= cur_cmd.pri;
            req_voice_index  <= cur_cmd.index;
            next_start = 1'b1;
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin : check_results
      voice_outcome_type want;
      if (!reset && rsp_valid) begin
         outcomes_seen++;
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_granted !== want.granted)
               report_mismatch("granted", rsp_granted, want.granted);
            if (rsp_granted_voice !== want.granted_voice)
               report_mismatch("granted_voice", rsp_granted_voice, want.granted_voice);
            if (rsp_stopped !== want.stopped)
               report_mismatch("stopped", rsp_stopped, want.stopped);
            if (rsp_stopped_voice !== want.stopped_voice)
               report_mismatch("stopped_voice", rsp_stopped_voice, want.stopped_voice);
            if (rsp_stopped_sound !== want.stopped_sound)
               report_mismatch("stopped_sound", rsp_stopped_sound, want.stopped_sound);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int phase_count [10] = '{4, 64, 0, 127, 3, 65, 16, 5, 33, 8};
      int phase_items [10] = '{220, 120, 220, 110, 220, 110, 220, 220, 150, 220};
      int phase_idle [4]   = '{0, 74, 0, 7};
      int start_pct;
      int org_list [8]     = '{0, 1, 2, 3, 4, 5, 6, 16'hFFFF};
      for (int v = 0; v < MAX_VOICES; v++) begin
         slot_busy[v]   = 1'b0;
         slot_origin[v] = '0;
         slot_sound[v]  = '0;
         slot_pri[v]    = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part, eight voices after reset
      queue_cmd(make_cmd(OP_NONE, 16'hFFFF, 1023, 255, 63));
      queue_cmd(make_cmd(OP_STOP, 0, 0, 0, 0));
      queue_cmd(make_cmd(OP_RELEASE, 0, 0, 0, 0));
      queue_cmd(make_cmd(OP_RELEASE, 0, 0, 0, 63));
      for (int k = 0; k < 8; k++) queue_cmd(make_cmd(OP_START, org_list[k], 10 + k, 100, 0));
      queue_cmd(make_cmd(OP_START, 9, 1023, 200, 0));       // full, nothing to steal
      queue_cmd(make_cmd(OP_START, 10, 0, 100, 0));         // steal, equal priority
      queue_cmd(make_cmd(OP_START, 16'hFFFF, 512, 255, 0)); // restart on same origin
      queue_cmd(make_cmd(OP_START, 0, 1, 0, 0));
      queue_cmd(make_cmd(OP_STOP, 3, 0, 0, 0));
      queue_cmd(make_cmd(OP_START, 5, 77, 7, 0));           // stop one, grant earlier hole
      queue_cmd(make_cmd(OP_RELEASE, 0, 0, 0, 2));
      queue_cmd(make_cmd(OP_RELEASE, 0, 0, 0, 2));          // already free
      queue_cmd(make_cmd(OP_START, 16'h8000, 1023, 0, 63));
      queue_cmd(make_cmd(OP_RELEASE, 0, 0, 0, 7));
      wait_drained();

      for (int p = 0; p < 10; p++) begin
         write_voice_count(CNT_W'(phase_count[p]));
         idle_pct  = phase_idle[p % 4];
         start_pct = (active_voices() > 32) ? 80 : 55;
         for (int k = 0; k < phase_items[p]; k++) queue_cmd(random_cmd(start_pct));
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (expected_outcomes.size() != 0)
         report_mismatch("results never delivered", 0, expected_outcomes.size());
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
